// File: rtl/particulate_frame_accumulator_macros.svh
`ifndef PARTICULATE_FRAME_ACCUMULATOR_MACROS_SVH
`define PARTICULATE_FRAME_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFA_ASSERT(lbl, prop, msg)
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/pfa_pkg.sv
package pfa_pkg;

    localparam logic [15:0] HEADER_WORD = 16'h4d42;
    localparam logic [7:0]  HDR_FIRST   = HEADER_WORD[7:0];
    localparam logic [7:0]  HDR_SECOND  = HEADER_WORD[15:8];

    localparam logic OP_BYTE     = 1'b0;
    localparam logic OP_REPORT   = 1'b1;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_BAD_HDR = 2'd1,
        STS_BAD_LEN = 2'd2,
        STS_BAD_CHK = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_EMIT,
        ST_REP_RD,
        ST_REP_WAIT
    } t_state;

    typedef struct packed {
        logic        kind;
        t_status     status;
        logic [3:0]  field_index;
        logic [31:0] sum;
        logic [15:0] frame_count;
        logic        last;
    } t_result;

endpackage

// File: rtl/pfa_ifs.sv
interface pfa_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, operation, data_byte, input ready);
    modport sink (input valid, operation, data_byte, output ready);
endinterface

interface pfa_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  status;
    logic [3:0]  field_index;
    logic [31:0] sum;
    logic [15:0] frame_count;
    logic        last;

    modport source (output valid, kind, status, field_index, sum, frame_count, last,
                    input ready);
    modport sink (input valid, kind, status, field_index, sum, frame_count, last,
                  output ready);
endinterface

// File: rtl/particulate_frame_accumulator.sv
// channel   dir  payload                                          role
// i_in      in   operation, data_byte                             sensor bytes, report request
// o_out     out  kind, status, field_index, sum, frame_count, last  frame status, sum report
//
// a byte that causes no result leaves the parser in ST_IDLE; a byte that ends in an error status passes through ST_EMIT
// a good frame folds its readings through the two rams, ST_ACC_RD then ST_ACC_WR per reading;
// ST_EMIT then registers its status, and i_in is ready again once back in ST_IDLE
// a report reads the sum ram entries in turn, ST_REP_RD then ST_REP_WAIT per entry
// i_rst_n clears parser, count and sum valid bits at once; no clearing pass
// the output register holds a result under stall and the sequencer waits behind it
`include "particulate_frame_accumulator_macros.svh"

module particulate_frame_accumulator
    import pfa_pkg::*;
#(
    parameter int DATA_WORDS = 12,
    parameter int SUM_WIDTH  = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfa_in_if.sink    i_in,
    pfa_out_if.source o_out
);

    localparam int IDX_W     = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int POS_W     = $clog2(2 * DATA_WORDS + 8);
    localparam int SUM_EXT_W = SUM_WIDTH + 1;

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(DATA_WORDS - 1);
    localparam logic [POS_W-1:0] CHK_HI_POS = POS_W'(2 * DATA_WORDS + 6);
    localparam logic [POS_W-1:0] CHK_LO_POS = POS_W'(2 * DATA_WORDS + 7);
    localparam logic [POS_W-1:0] WORDS_POS  = POS_W'(DATA_WORDS);
    localparam logic [15:0]      LEN_VALUE  = 16'(2 * DATA_WORDS + 4);

    t_state                r_state, n_state;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [15:0]           r_cs, n_cs;
    logic [7:0]            r_held, n_held;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [15:0]           r_good, n_good;
    logic [DATA_WORDS-1:0] r_sum_vld, n_sum_vld;
    t_status               r_pend, n_pend;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out, n_out;

    logic                  rdg_wr_en;
    logic [IDX_W-1:0]      rdg_wr_addr;
    logic [15:0]           rdg_rd_data;
    logic                  rdg_rd_en;
    logic                  sum_wr_en;
    logic [SUM_WIDTH-1:0]  sum_wr_data;
    logic                  sum_rd_en;
    logic [SUM_WIDTH-1:0]  sum_rd_data;

    logic                  in_xfer;
    logic                  out_free;
    logic [7:0]            in_byte;
    logic [15:0]           word;
    logic [POS_W-1:0]      word_slot;
    logic [SUM_WIDTH-1:0]  sum_cur;
    logic [SUM_EXT_W-1:0]  sum_ext;

    pfa_ram #(
        .WIDTH (16),
        .DEPTH (DATA_WORDS)
    ) u_readings (
        .i_clk     (i_clk),
        .i_wr_en   (rdg_wr_en),
        .i_wr_addr (rdg_wr_addr),
        .i_wr_data (word),
        .i_rd_en   (rdg_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (rdg_rd_data)
    );

    pfa_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (DATA_WORDS)
    ) u_sums (
        .i_clk     (i_clk),
        .i_wr_en   (sum_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (sum_wr_data),
        .i_rd_en   (sum_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (sum_rd_data)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign in_byte    = i_in.data_byte;
    assign word       = {r_held, in_byte};
    assign word_slot  = (r_pos - POS_W'(4)) >> 1;

    // never-written sums read as zero
    assign sum_cur     = r_sum_vld[r_idx] ? sum_rd_data : '0;
    assign sum_ext     = {1'b0, sum_cur} + SUM_EXT_W'(rdg_rd_data);
    assign sum_wr_data = sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_cs        = r_cs;
        n_held      = r_held;
        n_idx       = r_idx;
        n_good      = r_good;
        n_sum_vld   = r_sum_vld;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        rdg_wr_en   = 1'b0;
        rdg_wr_addr = word_slot[IDX_W-1:0];
        rdg_rd_en   = 1'b0;
        sum_wr_en   = 1'b0;
        sum_rd_en   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_in.operation == OP_REPORT) begin
                    n_idx   = '0;
                    n_state = ST_REP_RD;
                end else if (in_xfer) begin
                    priority if (r_pos == '0) begin
                        if (in_byte == HDR_FIRST) begin
                            n_cs  = {8'h00, in_byte};
                            n_pos = POS_W'(1);
                        end
                    end else if (r_pos == POS_W'(1)) begin
                        if (in_byte == HDR_SECOND) begin
                            n_cs  = r_cs + {8'h00, in_byte};
                            n_pos = POS_W'(2);
                        end else begin
                            n_pos   = '0;
                            n_pend  = STS_BAD_HDR;
                            n_state = ST_EMIT;
                        end
                    end else if (r_pos == POS_W'(2)) begin
                        n_held = in_byte;
                        n_cs   = r_cs + {8'h00, in_byte};
                        n_pos  = POS_W'(3);
                    end else if (r_pos == POS_W'(3)) begin
                        n_cs = r_cs + {8'h00, in_byte};
                        if (word != LEN_VALUE) begin
                            n_pos   = '0;
                            n_pend  = STS_BAD_LEN;
                            n_state = ST_EMIT;
                        end else begin
                            n_pos = POS_W'(4);
                        end
                    end else if (r_pos < CHK_HI_POS) begin
                        n_cs  = r_cs + {8'h00, in_byte};
                        n_pos = r_pos + POS_W'(1);
                        if (!r_pos[0]) begin
                            n_held = in_byte;
                        end else if (word_slot < WORDS_POS) begin
                            rdg_wr_en = 1'b1;
                        end
                    end else if (r_pos == CHK_HI_POS) begin
                        n_held = in_byte;
                        n_pos  = r_pos + POS_W'(1);
                    end else if (r_pos == CHK_LO_POS) begin
                        n_pos = '0;
                        if (word != r_cs) begin
                            n_pend  = STS_BAD_CHK;
                            n_state = ST_EMIT;
                        end else begin
                            n_idx   = '0;
                            n_state = ST_ACC_RD;
                        end
                    end else begin
                        n_pos = '0;
                    end
                end
            end
            ST_ACC_RD: begin
                rdg_rd_en = 1'b1;
                sum_rd_en = 1'b1;
                n_state   = ST_ACC_WR;
            end
            ST_ACC_WR: begin
                sum_wr_en        = 1'b1;
                n_sum_vld[r_idx] = 1'b1;
                if (r_idx == LAST_IDX) begin
                    if (r_good != 16'hffff) begin
                        n_good = r_good + 16'd1;
                    end
                    n_pend  = STS_OK;
                    n_state = ST_EMIT;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = ST_ACC_RD;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = KIND_STATUS;
                    n_out.status      = r_pend;
                    n_out.field_index = '0;
                    n_out.sum         = '0;
                    n_out.frame_count = r_good;
                    n_out.last        = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_REP_RD: begin
                sum_rd_en = 1'b1;
                n_state   = ST_REP_WAIT;
            end
            ST_REP_WAIT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = KIND_REPORT;
                    n_out.status      = STS_OK;
                    n_out.field_index = 4'(r_idx);
                    n_out.sum         = 32'(sum_cur);
                    n_out.frame_count = r_good;
                    n_out.last        = (r_idx == LAST_IDX);
                    if (r_idx == LAST_IDX) begin
                        n_sum_vld = '0;
                        n_good    = '0;
                        n_state   = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = ST_REP_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_cs        <= '0;
            r_idx       <= '0;
            r_good      <= '0;
            r_sum_vld   <= '0;
            r_pend      <= STS_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_cs        <= n_cs;
            r_idx       <= n_idx;
            r_good      <= n_good;
            r_sum_vld   <= n_sum_vld;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_held <= n_held;
        r_out  <= n_out;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.status      = r_out.status;
    assign o_out.field_index = r_out.field_index;
    assign o_out.sum         = r_out.sum;
    assign o_out.frame_count = r_out.frame_count;
    assign o_out.last        = r_out.last;

    `PFA_ASSERT(a_pos_range, r_pos <= CHK_LO_POS, "byte position beyond checksum")
    `PFA_ASSERT(a_status_shape,
        !(o_out.valid && o_out.kind == KIND_STATUS) ||
        (o_out.last && o_out.sum == 32'd0 && o_out.field_index == 4'd0),
        "malformed status result")
    `PFA_ASSERT_NEXT(a_report_clear,
        r_state == ST_REP_WAIT && out_free && r_idx == LAST_IDX,
        r_good == 16'd0 && r_sum_vld == '0,
        "sums not cleared after report")

endmodule

// File: rtl/pfa_ram.sv
module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
